@@ rtl/cpa_pkg.sv @@
// Package: types and constants for the contiguous pool allocator.
`default_nettype none
package cpa_pkg;
    localparam int MaxBlocks = 16;
    localparam int FreeDepth = MaxBlocks + 1;
    localparam int FreeIdxW  = $clog2(FreeDepth + 1);
    localparam int AllocIdxW = $clog2(MaxBlocks);
    localparam int AllocCntW = $clog2(MaxBlocks + 1);
    localparam int DataW     = 16;
    localparam int EntryW    = 2 * DataW;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StNoFit   = 3'd1;
    localparam logic [2:0] StFull    = 3'd2;
    localparam logic [2:0] StZero    = 3'd3;
    localparam logic [2:0] StUnknown = 3'd4;

    localparam logic [1:0] FitFirst = 2'd0;
    localparam logic [1:0] FitBest  = 2'd1;
    localparam logic [1:0] FitWorst = 2'd2;

    localparam logic CfgFitPolicy = 1'b0;
    localparam logic CfgPoolSize  = 1'b1;

    localparam logic [15:0] PoolReset = 16'd4096;

    typedef struct packed {
        logic        action;
        logic [15:0] req_size;
        logic [15:0] address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] address_res;
        logic [15:0] free_units;
    } out_item_t;
endpackage
`default_nettype wire

@@ rtl/contiguous_pool_allocator_top.sv @@
// Top level: contiguous pool allocator over a free-segment RAM and an allocated-block RAM.
//
// Usage: items enter on in_valid/in_stall with fields action, req_size, address.
// One result per item leaves on out_valid/out_stall with status, address_res and
// free_units. Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data)
// set fit policy (index 0) or pool size (index 1); a pool size write clears
// the block table and leaves one free segment of that size, or none for zero.
// Each item is processed alone by a sequencer that walks the free table RAM and
// the allocated table RAM one entry per cycle. An allocate scans the free table
// for a fit, commits the block and shifts the free table down when a segment is
// used up; a free looks up the block, scans for the insert point, commits and
// then shifts the free table down after a two-sided merge or up for an insert.
// A zero size or a full block table answers without any scan. The shift goes
// through the single write port of the free RAM, with a read and then a write
// per moved entry.
// After reset the tables hold one free segment [0, 4096) and no blocks; entry
// zero of the free RAM is seeded in the first cycle after reset, and no other
// clearing pass is needed since both tables use valid counts and bits.
// The result sits in an output register; when the receiver stalls, the result
// holds and no new item is taken until it is delivered.
`default_nettype none
module contiguous_pool_allocator_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire cpa_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cpa_pkg::out_item_t      out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import cpa_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_ASCAN  = 11'b00000000010,
        S_FSCAN  = 11'b00000000100,
        S_ACOMMIT= 11'b00000001000,
        S_SHDOWN = 11'b00000010000,
        S_BSCAN  = 11'b00000100000,
        S_PSCAN  = 11'b00001000000,
        S_FCOMMIT= 11'b00010000000,
        S_SHUP   = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } state_t;

    localparam int FaW = $clog2(FreeDepth);

    state_t                 state_reg, state_next;
    logic [1:0]             fit_reg;
    logic [15:0]            total_reg, total_next;
    logic [FreeIdxW-1:0]    fcnt_reg, fcnt_next;
    logic [MaxBlocks-1:0]   aval_reg, aval_next;
    in_item_t               item_reg;
    out_item_t              res_reg, res_next;
    logic                   ovalid_reg;
    logic [FreeIdxW-1:0]    idx_reg, idx_next;      // scan position (issued read)
    logic [FreeIdxW-1:0]    sel_reg, sel_next;      // chosen entry
    logic                   found_reg, found_next;
    logic [15:0]            sbase_reg, sbase_next, slen_reg, slen_next;
    logic [AllocIdxW:0]     slot_reg, slot_next;    // msb set means none
    logic [15:0]            blen_reg, blen_next;
    logic [15:0]            pbase_reg, pbase_next, plen_reg, plen_next; // previous entry
    logic                   rv_reg, rv_next;        // read data valid this cycle
    logic [FreeIdxW-1:0]    ridx_reg, ridx_next;    // index of read data
    logic [1:0]             step_reg, step_next;
    logic                   seed_reg;
    logic                   free_done;

    // Free table RAM
    logic                   f_we;
    logic [FaW-1:0]         f_waddr, f_raddr;
    logic [EntryW-1:0]      f_wdata, f_rdata;
    // Allocated table RAM
    logic                   a_we;
    logic [AllocIdxW-1:0]   a_waddr, a_raddr;
    logic [EntryW-1:0]      a_wdata, a_rdata;

    cpa_ram #(.Width(EntryW), .Depth(FreeDepth)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    cpa_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_alloc_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    logic [15:0] rd_base, rd_len, ad_base, ad_len;
    assign rd_base = f_rdata[EntryW-1:DataW];
    assign rd_len  = f_rdata[DataW-1:0];
    assign ad_base = a_rdata[EntryW-1:DataW];
    assign ad_len  = a_rdata[DataW-1:0];

    logic busy;
    assign busy      = (state_reg != S_IDLE);
    assign in_stall  = busy;
    assign cfg_ready = !busy;
    assign out_valid = ovalid_reg;
    assign out_item  = res_reg;

    logic cfg_wr, pool_wr;
    assign cfg_wr  = cfg_valid && cfg_ready;
    assign pool_wr = cfg_wr && (cfg_index == CfgPoolSize);

    logic [AllocIdxW-1:0] free_slot;
    logic                 any_slot;
    // Pick lowest free allocated slot
    always_comb
    begin
        free_slot = '0;
        any_slot  = 1'b0;
        for (int i = MaxBlocks - 1; i >= 0; i--)
        begin
            if (!aval_reg[i])
            begin
                free_slot = AllocIdxW'(i);
                any_slot  = 1'b1;
            end
        end
    end

    logic [16:0] end_prev;
    logic [16:0] blk_end;
    assign end_prev = {1'b0, pbase_reg} + {1'b0, plen_reg};
    assign blk_end  = {1'b0, item_reg.address} + {1'b0, blen_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        fcnt_next  = fcnt_reg;
        aval_next  = aval_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        found_next = found_reg;
        sbase_next = sbase_reg;
        slen_next  = slen_reg;
        slot_next  = slot_reg;
        blen_next  = blen_reg;
        pbase_next = pbase_reg;
        plen_next  = plen_reg;
        rv_next    = 1'b0;
        ridx_next  = idx_reg;
        step_next  = step_reg;
        free_done  = 1'b0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = idx_reg[FaW-1:0];
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_raddr = idx_reg[AllocIdxW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                found_next = 1'b0;
                slot_next = {1'b1, {AllocIdxW{1'b0}}};
                step_next = '0;
                if (in_valid)
                begin
                    if (!in_item.action)
                    begin
                        if (in_item.req_size == '0)
                        begin
                            res_next = '{StZero, 16'd0, total_reg};
                            state_next = S_OUT;
                        end
                        else if (!any_slot)
                        begin
                            res_next = '{StFull, 16'd0, total_reg};
                            state_next = S_OUT;
                        end
                        else
                        begin
                            slot_next = {1'b0, free_slot};
                            state_next = S_FSCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_ASCAN;
                    end
                end
            end

            // Look up allocated block by base
            S_ASCAN:
            begin
                a_raddr = idx_reg[AllocIdxW-1:0];
                if (rv_reg && aval_reg[ridx_reg[AllocIdxW-1:0]] && slot_reg[AllocIdxW]
                    && ad_base == item_reg.address)
                begin
                    slot_next = {1'b0, ridx_reg[AllocIdxW-1:0]};
                    blen_next = ad_len;
                end
                if (idx_reg < FreeIdxW'(MaxBlocks))
                begin
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg)
                begin
                    if (slot_next[AllocIdxW])
                    begin
                        res_next = '{StUnknown, 16'd0, total_reg};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = '0;
                        pbase_next = '0;
                        plen_next = '0;
                        sel_next = fcnt_reg;
                        found_next = 1'b0;
                        state_next = S_PSCAN;
                    end
                end
            end

            // Scan free table for fit
            S_FSCAN:
            begin
                if (rv_reg && rd_len >= item_reg.req_size)
                begin
                    if (!found_reg
                        || (fit_reg == FitBest && rd_len < slen_reg)
                        || (fit_reg == FitWorst && rd_len > slen_reg))
                    begin
                        found_next = 1'b1;
                        sel_next = ridx_reg;
                        sbase_next = rd_base;
                        slen_next = rd_len;
                    end
                end
                if (idx_reg < fcnt_reg && !(found_next && fit_reg != FitBest
                    && fit_reg != FitWorst))
                begin
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg || (found_next && fit_reg != FitBest
                    && fit_reg != FitWorst))
                begin
                    if (!found_next)
                    begin
                        res_next = '{StNoFit, 16'd0, total_reg};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_ACOMMIT;
                    end
                end
            end

            // Carve the block from the chosen segment
            S_ACOMMIT:
            begin
                a_we = 1'b1;
                a_waddr = slot_reg[AllocIdxW-1:0];
                a_wdata = {sbase_reg, item_reg.req_size};
                aval_next[slot_reg[AllocIdxW-1:0]] = 1'b1;
                total_next = total_reg - item_reg.req_size;
                res_next = '{StOk, sbase_reg, total_next};
                if (slen_reg == item_reg.req_size)
                begin
                    idx_next = sel_reg + 1'b1;
                    step_next = '0;
                    state_next = S_SHDOWN;
                end
                else
                begin
                    f_we = 1'b1;
                    f_waddr = sel_reg[FaW-1:0];
                    f_wdata = {sbase_reg + item_reg.req_size,
                               slen_reg - item_reg.req_size};
                    state_next = S_OUT;
                end
            end

            // Remove entry idx-1 by copying entries down, one read and one write per entry
            S_SHDOWN:
            begin
                if (idx_reg >= fcnt_reg)
                begin
                    fcnt_next = fcnt_reg - 1'b1;
                    state_next = S_OUT;
                end
                else if (step_reg == 2'd0)
                begin
                    f_raddr = idx_reg[FaW-1:0];
                    step_next = 2'd1;
                end
                else
                begin
                    f_we = 1'b1;
                    f_waddr = FaW'(idx_reg - 1'b1);
                    f_wdata = f_rdata;
                    idx_next = idx_reg + 1'b1;
                    step_next = 2'd0;
                end
            end

            // Find insert point p: first entry with base >= address
            S_PSCAN:
            begin
                if (rv_reg && !found_reg)
                begin
                    if (rd_base < item_reg.address)
                    begin
                        pbase_next = rd_base;
                        plen_next = rd_len;
                    end
                    else
                    begin
                        found_next = 1'b1;
                        sel_next = ridx_reg;
                        sbase_next = rd_base;
                        slen_next = rd_len;
                    end
                end
                if (idx_reg < fcnt_reg && !found_next)
                begin
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rv_reg || found_next)
                begin
                    state_next = S_FCOMMIT;
                end
            end

            // Merge or insert the freed block
            S_FCOMMIT:
            begin
                free_done = 1'b1;
                if (sel_reg != '0 && end_prev == {1'b0, item_reg.address} && found_reg
                    && blk_end == {1'b0, sbase_reg})
                begin
                    f_we = 1'b1;
                    f_waddr = FaW'(sel_reg - 1'b1);
                    f_wdata = {pbase_reg, plen_reg + blen_reg + slen_reg};
                    idx_next = sel_reg + 1'b1;
                    step_next = '0;
                    state_next = S_SHDOWN;
                end
                else if (sel_reg != '0 && end_prev == {1'b0, item_reg.address})
                begin
                    f_we = 1'b1;
                    f_waddr = FaW'(sel_reg - 1'b1);
                    f_wdata = {pbase_reg, plen_reg + blen_reg};
                    state_next = S_OUT;
                end
                else if (found_reg && blk_end == {1'b0, sbase_reg})
                begin
                    f_we = 1'b1;
                    f_waddr = sel_reg[FaW-1:0];
                    f_wdata = {item_reg.address, slen_reg + blen_reg};
                    state_next = S_OUT;
                end
                else if (fcnt_reg >= FreeIdxW'(FreeDepth))
                begin
                    free_done = 1'b0;
                    res_next = '{StFull, 16'd0, total_reg};
                    state_next = S_OUT;
                end
                else
                begin
                    free_done = 1'b0;
                    idx_next = fcnt_reg;
                    step_next = '0;
                    state_next = S_SHUP;
                end
                if (free_done)
                begin
                    aval_next[slot_reg[AllocIdxW-1:0]] = 1'b0;
                    total_next = total_reg + blen_reg;
                    res_next = '{StOk, 16'd0, total_next};
                end
            end

            // Shift entries up from the end to open a hole at sel
            S_SHUP:
            begin
                if (idx_reg == sel_reg)
                begin
                    f_we = 1'b1;
                    f_waddr = sel_reg[FaW-1:0];
                    f_wdata = {item_reg.address, blen_reg};
                    fcnt_next = fcnt_reg + 1'b1;
                    aval_next[slot_reg[AllocIdxW-1:0]] = 1'b0;
                    total_next = total_reg + blen_reg;
                    res_next = '{StOk, 16'd0, total_next};
                    state_next = S_OUT;
                end
                else if (step_reg == 2'd0)
                begin
                    f_raddr = FaW'(idx_reg - 1'b1);
                    step_next = 2'd1;
                end
                else
                begin
                    f_we = 1'b1;
                    f_waddr = idx_reg[FaW-1:0];
                    f_wdata = f_rdata;
                    idx_next = idx_reg - 1'b1;
                    step_next = 2'd0;
                end
            end

            S_OUT:
            begin
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Seed entry zero with the reset pool in the first cycle after reset
        if (seed_reg)
        begin
            f_we = 1'b1;
            f_waddr = '0;
            f_wdata = {16'd0, PoolReset};
        end

        // Pool reinit writes entry zero
        if (pool_wr)
        begin
            f_we = 1'b1;
            f_waddr = '0;
            f_wdata = {16'd0, cfg_data};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_item;
        end
        res_reg   <= res_next;
        idx_reg   <= idx_next;
        sel_reg   <= sel_next;
        sbase_reg <= sbase_next;
        slen_reg  <= slen_next;
        slot_reg  <= slot_next;
        blen_reg  <= blen_next;
        pbase_reg <= pbase_next;
        plen_reg  <= plen_next;
        ridx_reg  <= ridx_next;
        step_reg  <= step_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fit_reg    <= FitFirst;
            total_reg  <= PoolReset;
            fcnt_reg   <= FreeIdxW'(1);
            aval_reg   <= '0;
            ovalid_reg <= 1'b0;
            found_reg  <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            rv_reg    <= rv_next;
            total_reg <= total_next;
            fcnt_reg  <= fcnt_next;
            aval_reg  <= aval_next;
            if (state_reg == S_OUT)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_wr && cfg_index == CfgFitPolicy)
            begin
                fit_reg <= cfg_data[1:0];
            end
            if (pool_wr)
            begin
                total_reg <= cfg_data;
                fcnt_reg  <= (cfg_data == '0) ? '0 : FreeIdxW'(1);
                aval_reg  <= '0;
            end
        end
    end

    // Reset leaves entry zero of the free RAM unwritten; seed it once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 1'b1;
        end
        else
        begin
            seed_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ rtl/cpa_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cpa_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/cpa_checker.sv @@
// Port-level assertions for the contiguous pool allocator.
`default_nettype none
module cpa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire cpa_pkg::out_item_t out_item,
    input wire logic               cfg_ready
);
    import cpa_pkg::*;

    // Busy after accepting an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while not busy afterward");

    // Config port closed while busy
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("config ready while busy");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");

    // Failure carries zero address
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status != StOk) |-> out_item.address_res == 16'd0)
        else $error("failed item has nonzero address");
endmodule

bind contiguous_pool_allocator_top cpa_checker u_cpa_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ bench/tb_contiguous_pool_allocator_top.sv @@
// Testbench: random and directed allocate/free traffic checked against a behavioral pool model.
`default_nettype none
module tb_contiguous_pool_allocator_top;
    import cpa_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [15:0] cfg_data;

    contiguous_pool_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pool model state
    logic [15:0] seg_base [FreeDepth];
    logic [15:0] seg_len  [FreeDepth];
    logic        seg_used [FreeDepth];
    logic [15:0] blk_base [MaxBlocks];
    logic [15:0] blk_len  [MaxBlocks];
    logic        blk_used [MaxBlocks];
    logic [16:0] pool_free;
    logic [1:0]  policy;
    logic [15:0] pool_units;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        mismatch_count;
    int        sent_count;
    bit        quiet;
    bit        hold_send;
    int        in_gap;
    int        out_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic pool_init();
        for (int i = 0; i < FreeDepth; i++)
        begin
            seg_base[i] = '0;
            seg_len[i]  = '0;
            seg_used[i] = 1'b0;
        end
        for (int i = 0; i < MaxBlocks; i++)
        begin
            blk_base[i] = '0;
            blk_len[i]  = '0;
            blk_used[i] = 1'b0;
        end
        if (pool_units != 0)
        begin
            seg_len[0]  = pool_units;
            seg_used[0] = 1'b1;
        end
        pool_free = {1'b0, pool_units};
    endtask

    function automatic int seg_count();
        int n;
        n = 0;
        while (n < FreeDepth && seg_used[n])
            n++;
        return n;
    endfunction

    task automatic seg_drop(input int p, input int n);
        for (int i = p; i + 1 < n; i++)
        begin
            seg_base[i] = seg_base[i + 1];
            seg_len[i]  = seg_len[i + 1];
        end
        seg_base[n - 1] = '0;
        seg_len[n - 1]  = '0;
        seg_used[n - 1] = 1'b0;
    endtask

    // Compute the result of one item and update the pool model
    task automatic pool_apply(input in_item_t it, output out_item_t res);
        int n, slot, c, p;
        logic [15:0] len;
        logic [16:0] sum_prev, sum_next;
        bit pt, nt;
        logic [2:0] st;
        logic [15:0] addr;
        n = seg_count();
        slot = -1;
        c = -1;
        addr = '0;
        st = StOk;
        if (it.action == 1'b0)
        begin
            for (int i = 0; i < MaxBlocks; i++)
                if (!blk_used[i] && slot < 0)
                    slot = i;
            if (it.req_size == 0)
                st = StZero;
            else if (slot < 0)
                st = StFull;
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (seg_len[i] >= it.req_size)
                    begin
                        if (policy == FitBest)
                        begin
                            if (c < 0 || seg_len[i] < seg_len[c])
                                c = i;
                        end
                        else if (policy == FitWorst)
                        begin
                            if (c < 0 || seg_len[i] > seg_len[c])
                                c = i;
                        end
                        else if (c < 0)
                            c = i;
                    end
                end
                if (c < 0)
                    st = StNoFit;
                else
                begin
                    addr = seg_base[c];
                    seg_base[c] = seg_base[c] + it.req_size;
                    seg_len[c]  = seg_len[c] - it.req_size;
                    if (seg_len[c] == 0)
                        seg_drop(c, n);
                    blk_base[slot] = addr;
                    blk_len[slot]  = it.req_size;
                    blk_used[slot] = 1'b1;
                    pool_free = pool_free - it.req_size;
                end
            end
        end
        else
        begin
            for (int i = 0; i < MaxBlocks; i++)
                if (blk_used[i] && blk_base[i] == it.address && slot < 0)
                    slot = i;
            if (slot < 0)
                st = StUnknown;
            else
            begin
                len = blk_len[slot];
                p = 0;
                while (p < n && seg_base[p] < it.address)
                    p++;
                sum_prev = (p > 0) ? {1'b0, seg_base[p - 1]} + seg_len[p - 1] : '0;
                sum_next = {1'b0, it.address} + len;
                pt = (p > 0) && (sum_prev == {1'b0, it.address});
                nt = (p < n) && (sum_next == {1'b0, seg_base[p]});
                if (pt && nt)
                begin
                    seg_len[p - 1] = seg_len[p - 1] + len + seg_len[p];
                    seg_drop(p, n);
                end
                else if (pt)
                    seg_len[p - 1] = seg_len[p - 1] + len;
                else if (nt)
                begin
                    seg_base[p] = it.address;
                    seg_len[p]  = seg_len[p] + len;
                end
                else if (n >= FreeDepth)
                    st = StFull;
                else
                begin
                    for (int i = n; i > p; i--)
                    begin
                        seg_base[i] = seg_base[i - 1];
                        seg_len[i]  = seg_len[i - 1];
                    end
                    seg_base[p] = it.address;
                    seg_len[p]  = len;
                    seg_used[n] = 1'b1;
                end
                if (st == StOk)
                begin
                    blk_used[slot] = 1'b0;
                    blk_base[slot] = '0;
                    blk_len[slot]  = '0;
                    pool_free = pool_free + len;
                end
            end
        end
        res.status      = st;
        res.address_res = (st == StOk) ? addr : 16'd0;
        res.free_units  = pool_free[15:0];
    endtask

    // Pick a live block base, or a random address when none is held
    function automatic logic [15:0] live_base();
        int picks [$];
        for (int i = 0; i < MaxBlocks; i++)
            if (blk_used[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return 16'($urandom);
        return blk_base[picks[$urandom_range(picks.size() - 1)]];
    endfunction

    task automatic queue_item(input logic act, input logic [15:0] sz,
                              input logic [15:0] addr);
        in_item_t it;
        out_item_t res;
        it.action   = act;
        it.req_size = sz;
        it.address  = addr;
        pool_apply(it, res);
        pending_items.push_back(it);
        expected_results.push_back(res);
    endtask

    task automatic wait_drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CfgFitPolicy)
            policy = val[1:0];
        else
        begin
            pool_units = val;
            pool_init();
        end
    endtask

    // Random phase: mostly allocate/free of live blocks, some noise
    task automatic random_phase(input int count, input int max_size);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                queue_item(1'b0, 16'($urandom_range(max_size, 1)), 16'($urandom));
            else if (r < 85)
                queue_item(1'b1, 16'($urandom), live_base());
            else if (r < 92)
                queue_item(1'b1, 16'($urandom), 16'($urandom));
            else if (r < 96)
                queue_item(1'b0, 16'($urandom), 16'($urandom));
            else
                queue_item(1'b0, 16'd0, 16'($urandom));
        end
    endtask

    // Driver: present queued items, idle in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                void'(pending_items.pop_front());
                sent_count <= sent_count + 1;
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled item
            end
            else if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(9) == 0)
            begin
                in_gap   <= $urandom_range(17, 1) - 1;
                in_valid <= 1'b0;
            end
            else if (hold_send)
                in_valid <= 1'b0;
            else if (pending_items.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item  <= pending_items[0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: stall in random bursts and check each result
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", out_item);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status !== out_item.status
                        || want.address_res !== out_item.address_res
                        || want.free_units !== out_item.free_units)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp st=%0d addr=%0d free=%0d got st=%0d addr=%0d free=%0d",
                                want.status, want.address_res, want.free_units,
                                out_item.status, out_item.address_res, out_item.free_units);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(9) == 0)
            begin
                out_gap   <= $urandom_range(17, 1) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        mismatch_count = 0;
        sent_count = 0;
        quiet = 1'b0;
        hold_send = 1'b0;
        policy = FitFirst;
        pool_units = PoolReset;
        pool_init();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CfgFitPolicy;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset pool, zero size, extremes, unknown and double free
        queue_item(1'b0, 16'd0, 16'hFFFF);
        queue_item(1'b0, 16'hFFFF, 16'd0);
        queue_item(1'b0, 16'd100, 16'd0);
        queue_item(1'b0, 16'd200, 16'd0);
        queue_item(1'b0, 16'd300, 16'd0);
        queue_item(1'b1, 16'hFFFF, 16'd50);
        queue_item(1'b1, 16'd0, 16'd100);
        queue_item(1'b1, 16'd0, 16'd100);
        queue_item(1'b1, 16'd0, 16'd0);
        queue_item(1'b1, 16'd0, 16'd300);
        queue_item(1'b0, 16'd3796, 16'd0);
        queue_item(1'b0, 16'd1, 16'd0);
        wait_drain();

        // Full block table at the widest pool, then merge on both sides
        cfg_write(CfgPoolSize, 16'hFFFF);
        for (int i = 0; i < MaxBlocks; i++)
            queue_item(1'b0, 16'd10, 16'd0);
        queue_item(1'b0, 16'd10, 16'd0);
        queue_item(1'b1, 16'd0, 16'd10);
        queue_item(1'b1, 16'd0, 16'd30);
        queue_item(1'b1, 16'd0, 16'd20);
        wait_drain();

        // Zero pool
        cfg_write(CfgPoolSize, 16'd0);
        queue_item(1'b0, 16'd1, 16'd0);
        wait_drain();

        // Random phases over each policy and pool size
        for (int ph = 0; ph < 8; ph++)
        begin
            cfg_write(CfgFitPolicy, 16'(ph % 4));
            case (ph)
                0: cfg_write(CfgPoolSize, 16'd1);
                1: cfg_write(CfgPoolSize, 16'hFFFF);
                2: cfg_write(CfgPoolSize, 16'd64);
                default: cfg_write(CfgPoolSize, 16'($urandom_range(65535, 1)));
            endcase
            if (ph == 7)
                quiet = 1'b1;
            random_phase(64, (ph == 0) ? 2 : ((pool_units > 1024) ? 4096 : pool_units));
            if (ph == 3)
            begin
                // let part of the phase go out, then hold off the sender
                // until all results are back
                while (pending_items.size() > 32)
                    @(posedge clk);
                hold_send = 1'b1;
                while (expected_results.size() > pending_items.size())
                    @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drain();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
